FILE: design/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg: shared types, constants and functions for the ray/box slab test
// Register indexes, pipeline depths, divider word types and the slab setup
// and finish functions used by the top level and the divider.
// ----------------------------------------------------------------------------
package rbs_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
   localparam logic [2:0] REG_HEADING_X = 3'd3;
   localparam logic [2:0] REG_HEADING_Y = 3'd4;
   localparam logic [2:0] REG_HEADING_Z = 3'd5;

   localparam int COORD_W   = 32;
   localparam int HEAD_W    = 18;
   localparam int QUOT_W    = 32;
   localparam int STEP_BITS = 2;
   // Divider stages, each retiring STEP_BITS quotient bits
   localparam int DIV_STAGES = QUOT_W / STEP_BITS;
   // Input stage, divider setup stage, divider stages, finish stage, result stage
   localparam int NUM_STAGES = DIV_STAGES + 4;

   localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;
   localparam logic signed [HEAD_W-1:0]  HEADING_Z_RESET = 18'sh10000;

   typedef struct packed {
      logic neg;       // quotient sign
      logic force_t;   // result is a fixed extreme value
      logic force_hi;  // extreme is T_MAX when set, T_MIN otherwise
   } meta_type;

   typedef struct packed {
      logic [HEAD_W-1:0] rem;   // partial remainder
      logic [QUOT_W-1:0] bits;  // dividend bits left, quotient bits shifted in
      logic [HEAD_W-1:0] dvs;   // divisor magnitude
      meta_type          meta;
   } div_word_type;

   // Set up one slab bound: numerator magnitude, divisor magnitude, specials
   function automatic div_word_type prep_bound(input logic signed [COORD_W-1:0] corner,
                                               input logic signed [COORD_W-1:0] origin,
                                               input logic signed [HEAD_W-1:0] heading,
                                               input logic entry);
      logic signed [COORD_W:0] num;
      logic [COORD_W:0]        nmag;
      logic [HEAD_W-1:0]       dmag;
      div_word_type            w;
      num  = {corner[COORD_W-1], corner} - {origin[COORD_W-1], origin};
      nmag = num[COORD_W] ? -num : num;
      dmag = heading[HEAD_W-1] ? -heading : heading;
      w.rem  = {1'b0, nmag[COORD_W:16]};
      w.bits = {nmag[15:0], 16'h0000};
      w.dvs  = dmag;
      w.meta.neg = num[COORD_W] ^ heading[HEAD_W-1];
      if (heading == '0) begin
         w.meta.force_t  = 1'b1;
         w.meta.force_hi = (num == '0) ? !entry : !num[COORD_W];
      end else if ({1'b0, nmag[COORD_W:16]} >= dmag) begin
         // quotient at least 2^32: saturates either way
         w.meta.force_t  = 1'b1;
         w.meta.force_hi = !w.meta.neg;
      end else begin
         w.meta.force_t  = 1'b0;
         w.meta.force_hi = 1'b0;
      end
      return w;
   endfunction

   // Apply sign and saturation to a quotient magnitude
   function automatic logic signed [COORD_W-1:0] finish_bound(input logic [QUOT_W-1:0] q,
                                                              input meta_type meta);
      logic signed [COORD_W-1:0] t;
      if (meta.force_t) begin
         t = meta.force_hi ? T_MAX : T_MIN;
      end else if (!meta.neg) begin
         t = q[QUOT_W-1] ? T_MAX : q;
      end else begin
         t = (q > 32'h8000_0000) ? T_MIN : -q;
      end
      return t;
   endfunction

endpackage

FILE: design/rbs_div.sv
// ----------------------------------------------------------------------------
// rbs_div: pipelined restoring divider for one slab bound
// Stage 0 captures the setup word; each later stage retires two quotient
// bits. Stages load on their own load strobe supplied by the top level.
// ----------------------------------------------------------------------------
module rbs_div (
   input  logic                          clock,
   input  logic [rbs_pkg::DIV_STAGES:0]  load,
   input  rbs_pkg::div_word_type         word_in,
   output logic [rbs_pkg::QUOT_W-1:0]    quot,
   output rbs_pkg::meta_type             meta
);
   import rbs_pkg::*;

   div_word_type stage_ff [0:DIV_STAGES];
   div_word_type stage_in [0:DIV_STAGES];

   // Two restoring steps on one word
   function automatic div_word_type div_step(input div_word_type w);
      logic [HEAD_W:0] t;
      div_word_type    r;
      r = w;
      for (int s = 0; s < STEP_BITS; s++) begin
         t      = {r.rem, r.bits[QUOT_W-1]};
         r.bits = {r.bits[QUOT_W-2:0], 1'b0};
         if (t >= {1'b0, r.dvs}) begin
            r.rem     = HEAD_W'(t - {1'b0, r.dvs});
            r.bits[0] = 1'b1;
         end else begin
            r.rem = t[HEAD_W-1:0];
         end
      end
      return r;
   endfunction

   // Next value of every stage
   always_comb begin
      stage_in[0] = word_in;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         stage_in[k] = div_step(stage_ff[k-1]);
      end
   end

   // Advance the stages that are told to load
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign quot = stage_ff[DIV_STAGES].bits;
   assign meta = stage_ff[DIV_STAGES].meta;

endmodule

FILE: design/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test: ray versus axis-aligned box slab test
// An accepted box word passes the input, divider setup, divider, finish and result stages in order.
// Throughput: one box word per cycle while rsp_ready holds; the 16 two-bit divider stages set depth.
// Each stage holds its word while the next one is full and stalled.
// Reset clears all stage valid bits and loads the ray registers with their
// reset values (origin zero, heading along +z).
// ----------------------------------------------------------------------------
module ray_box_slab_test (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_min_x,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_min_y,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_min_z,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_max_x,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_max_y,
   input  logic signed [rbs_pkg::COORD_W-1:0] req_box_max_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [31:0]                       csr_data
);
   import rbs_pkg::*;

   localparam int LAST = NUM_STAGES - 1;
   localparam int FIN  = NUM_STAGES - 2;

   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [HEAD_W-1:0]  heading_x_ff, heading_y_ff, heading_z_ff;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, ready;

   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [COORD_W-1:0] max_x_ff, max_y_ff, max_z_ff;

   div_word_type        prep [0:5];
   logic [QUOT_W-1:0]   quot [0:5];
   meta_type            meta [0:5];
   logic signed [COORD_W-1:0] t_ff [0:5];
   logic signed [COORD_W-1:0] t_in [0:5];
   logic                hit_ff, hit_in;

   // Configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         heading_x_ff <= '0;
         heading_y_ff <= '0;
         heading_z_ff <= HEADING_Z_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ORIGIN_X:  origin_x_ff  <= csr_data;
            REG_ORIGIN_Y:  origin_y_ff  <= csr_data;
            REG_ORIGIN_Z:  origin_z_ff  <= csr_data;
            REG_HEADING_X: heading_x_ff <= csr_data[HEAD_W-1:0];
            REG_HEADING_Y: heading_y_ff <= csr_data[HEAD_W-1:0];
            REG_HEADING_Z: heading_z_ff <= csr_data[HEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage ready chain: a stage loads when empty or when its word moves on
   always_comb begin
      ready[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready[0];
   assign rsp_valid = valid_ff[LAST];
   assign rsp_hit   = hit_ff;

   // Capture the box word
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         min_x_ff <= req_box_min_x;
         min_y_ff <= req_box_min_y;
         min_z_ff <= req_box_min_z;
         max_x_ff <= req_box_max_x;
         max_y_ff <= req_box_max_y;
         max_z_ff <= req_box_max_z;
      end
   end

   // Set up entry and exit bounds, swapping corners on a negative heading
   always_comb begin
      prep[0] = prep_bound(heading_x_ff[HEAD_W-1] ? max_x_ff : min_x_ff,
                           origin_x_ff, heading_x_ff, 1'b1);
      prep[1] = prep_bound(heading_x_ff[HEAD_W-1] ? min_x_ff : max_x_ff,
                           origin_x_ff, heading_x_ff, 1'b0);
      prep[2] = prep_bound(heading_y_ff[HEAD_W-1] ? max_y_ff : min_y_ff,
                           origin_y_ff, heading_y_ff, 1'b1);
      prep[3] = prep_bound(heading_y_ff[HEAD_W-1] ? min_y_ff : max_y_ff,
                           origin_y_ff, heading_y_ff, 1'b0);
      prep[4] = prep_bound(heading_z_ff[HEAD_W-1] ? max_z_ff : min_z_ff,
                           origin_z_ff, heading_z_ff, 1'b1);
      prep[5] = prep_bound(heading_z_ff[HEAD_W-1] ? min_z_ff : max_z_ff,
                           origin_z_ff, heading_z_ff, 1'b0);
   end

   // One divider per bound
   for (genvar b = 0; b < 6; b++) begin : g_div
      rbs_div u_div (
         .clock   (clock),
         .load    (ready[DIV_STAGES+1:1]),
         .word_in (prep[b]),
         .quot    (quot[b]),
         .meta    (meta[b])
      );
   end

   // Sign and saturate the distances
   always_comb begin
      for (int b = 0; b < 6; b++) begin
         t_in[b] = finish_bound(quot[b], meta[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[FIN]) begin
         for (int b = 0; b < 6; b++) begin
            t_ff[b] <= t_in[b];
         end
      end
   end

   // Intersect the slab intervals in x, y, z order
   always_comb begin
      logic signed [COORD_W-1:0] tn, tx;
      tn = (t_ff[2] > t_ff[0]) ? t_ff[2] : t_ff[0];
      tx = (t_ff[3] < t_ff[1]) ? t_ff[3] : t_ff[1];
      hit_in = !((t_ff[0] > t_ff[3]) || (t_ff[2] > t_ff[1]) ||
                 (tn > t_ff[5]) || (t_ff[4] > tx));
   end

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         hit_ff <= hit_in;
      end
   end

endmodule
